/* sv/ant_pkg.sv */
// Package for the aging node table: opcodes, status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package ant_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_FIND_A = 3'd1,
    OP_FIND_H = 3'd2,
    OP_UPDATE = 3'd3,
    OP_REMOVE = 3'd4,
    OP_REFRESH = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_SCAN,
    S_WR,
    S_FREE
  } state_t;

  localparam int EntryW = 280;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

endpackage

/* sv/ant_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ant_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* sv/aging_node_table.sv */
`timescale 1ns / 1ps
// Aging node table. How long one item takes depends on the
// operation: each scan (lookup, free-slot search, refresh) walks the entry
// memory one slot per cycle through its single port, except where a refresh
// writes back an expired entry, which forces a reread. An add writes the
// entry, then searches for the next free slot; update and remove read the
// target slot, then write it back; a rejected or unknown request is answered
// straight from the idle state. After reset a clearing pass zeroes the memory
// before the first item is taken. The result sits in an output register;
// in_tready is low while an item is in work.
module aging_node_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[2:0], now[34:3], addr_hi[98:35], addr_lo[162:99], key_hash[194:163],
  // payload[226:195], version[242:227], node_kind[250:243], slot[254:251]
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], slot_out[5:2], found_addr_hi[69:6], found_addr_lo[133:70],
  // found_hash[165:134], found_data[197:166], found_version[213:198],
  // found_kind[221:214], created_time[253:222], last_time[285:254],
  // next_check[317:286]
  output logic [319:0] out_tdata
);
  import ant_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LastC = CW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] FullC = CW'(TABLE_ENTRIES);

  // entry layout: addr_hi, addr_lo, hash, data, version, kind, created, last
  logic [EntryW-1:0] rdata, wdata;
  logic              we;
  logic [AW-1:0]     addr;

  ant_ram #(.Width(EntryW), .Depth(1 << AW)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  state_t state_r, state_nxt;
  logic [255:0] item_r, item_nxt;
  logic [31:0]  timeout_r;
  logic [CW-1:0] idx_r, idx_nxt, free_r, free_nxt;
  logic [31:0]  next_r, next_nxt;
  logic         any_r, any_nxt, full_r, full_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [319:0] odata_r, odata_nxt;

  logic [2:0]  op;
  logic [31:0] now_i;
  logic [3:0]  slot_i;
  logic [CW-1:0] slot_c;
  assign op     = item_r[2:0];
  assign now_i  = item_r[34:3];
  assign slot_i = item_r[254:251];
  assign slot_c = CW'(slot_i);

  logic [63:0] e_hi, e_lo;
  logic [31:0] e_hash, e_last, elapsed, remain;
  assign e_hi    = rdata[279:216];
  assign e_lo    = rdata[215:152];
  assign e_hash  = rdata[151:120];
  assign e_last  = rdata[31:0];
  assign elapsed = now_i - e_last;
  assign remain  = timeout_r - elapsed;

  logic e_empty;
  assign e_empty = (e_hi == 64'd0) && (e_lo == 64'd0);

  // scan position: read address in S_SCAN runs one ahead of the compare
  logic [CW-1:0] cmp_r, cmp_nxt;

  function automatic logic [319:0] pack_entry(input logic [1:0] st, input logic [3:0] s,
                                              input logic [EntryW-1:0] e);
    pack_entry = {34'd0, e[31:0], e[63:32], e[71:64], e[87:72], e[119:88],
                  e[151:120], e[215:152], e[279:216], s, st};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      idx_r    <= '0;
      free_r   <= '0;
      timeout_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      free_r   <= free_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) timeout_r <= cfg_wdata;
    end
    item_r  <= item_nxt;
    next_r  <= next_nxt;
    any_r   <= any_nxt;
    full_r  <= full_nxt;
    cmp_r   <= cmp_nxt;
    odata_r <= odata_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    idx_nxt    = idx_r;
    free_nxt   = free_r;
    next_nxt   = next_r;
    any_nxt    = any_r;
    full_nxt   = full_r;
    cmp_nxt    = cmp_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    we    = 1'b0;
    addr  = idx_r[AW-1:0];
    wdata = rdata;
    in_tready = 1'b0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LastC) begin
          idx_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = !ovalid_r || out_tready;
        if (in_tvalid && in_tready) begin
          item_nxt  = in_tdata;
          idx_nxt   = '0;
          cmp_nxt   = '0;
          any_nxt   = 1'b0;
          full_nxt  = 1'b0;
          next_nxt  = AllOnes;
          odata_nxt = '0;
          odata_nxt[1:0] = ST_NOTFOUND;
          case (in_tdata[2:0])
            OP_ADD: begin
              if (free_r == FullC) begin
                odata_nxt[1:0] = ST_FULL;
                ovalid_nxt = 1'b1;
              end else begin
                idx_nxt = free_r;
                state_nxt = S_WR;
              end
            end
            OP_FIND_A, OP_FIND_H, OP_REFRESH: state_nxt = S_SCAN;
            OP_UPDATE, OP_REMOVE: begin
              if (CW'(in_tdata[254:251]) >= FullC) begin
                ovalid_nxt = 1'b1;
              end else begin
                idx_nxt = CW'(in_tdata[254:251]);
                state_nxt = S_RD;
              end
            end
            default: ovalid_nxt = 1'b1;
          endcase
        end
      end
      S_RD: begin
        // read issued; next cycle rdata holds the target entry
        state_nxt = S_WR;
        full_nxt = 1'b1;
      end
      S_WR: begin
        if (op == OP_ADD) begin
          we = 1'b1;
          wdata = {item_r[98:35], item_r[162:99], item_r[194:163], item_r[226:195],
                   item_r[242:227], item_r[250:243], now_i, now_i};
          odata_nxt = pack_entry(ST_OK, idx_r[3:0], wdata);
          idx_nxt = '0;
          cmp_nxt = '0;
          state_nxt = S_FREE;
        end else if (!full_r) begin
          state_nxt = S_RD;
        end else begin
          we = 1'b1;
          if (op == OP_UPDATE) begin
            wdata = {rdata[279:120], item_r[226:195], item_r[242:227], rdata[71:32], now_i};
            odata_nxt = pack_entry(ST_OK, slot_i, wdata);
          end else begin
            wdata = {64'd0, 64'd0, 32'd0, rdata[119:0]};
            free_nxt = slot_c;
            odata_nxt = '0;
            odata_nxt[1:0] = ST_OK;
            odata_nxt[5:2] = slot_i;
          end
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        // after add: find first empty slot; cmp_r is the slot in rdata
        addr = idx_r[AW-1:0];
        if (idx_r != FullC) idx_nxt = idx_r + 1'b1;
        if (idx_r != '0) begin
          cmp_nxt = cmp_r + 1'b1;
          if (e_empty) begin
            free_nxt = cmp_r;
            ovalid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else if (cmp_r == LastC) begin
            free_nxt = FullC;
            ovalid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        addr = idx_r[AW-1:0];
        if (idx_r != FullC) idx_nxt = idx_r + 1'b1;
        if (idx_r != '0 && idx_r != cmp_r) begin
          cmp_nxt = cmp_r + 1'b1;
          if (op == OP_REFRESH) begin
            // An expired entry is written back at once, which steals the
            // port from the read running ahead.
            if (!e_empty) begin
              if (elapsed >= timeout_r) begin
                addr = cmp_r[AW-1:0];
                we = 1'b1;
                wdata = {64'd0, 64'd0, 32'd0, rdata[119:0]};
                free_nxt = cmp_r;
                idx_nxt = cmp_r + 1'b1;
                cmp_nxt = cmp_r + 1'b1;
                // restart reading at the following slot
              end else begin
                any_nxt = 1'b1;
                if (remain < next_r) next_nxt = remain;
              end
            end
            if (cmp_r == LastC) begin
              odata_nxt = '0;
              odata_nxt[1:0] = ST_OK;
              odata_nxt[317:286] = (any_nxt) ? next_nxt : AllOnes;
              ovalid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            if ((op == OP_FIND_A) ? (e_hi == item_r[98:35] && e_lo == item_r[162:99])
                                  : (e_hash == item_r[194:163])) begin
              odata_nxt = pack_entry(ST_OK, cmp_r[3:0], rdata);
              ovalid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else if (cmp_r == LastC) begin
              ovalid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        end else if (idx_r != '0) begin
          // a write disturbed the read pipeline; reread this slot
          idx_nxt = idx_r + 1'b1;
          addr = idx_r[AW-1:0];
          cmp_nxt = idx_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule

/* sim/node_table_checker.sv */
// Checker for the aging node table: watches the input, config and result
// channels, keeps its own copy of the table and compares every result.
// Depends on ant_pkg.
`timescale 1ns / 1ps
module node_table_checker #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [255:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [319:0] out_tdata,
  output int           err_count,
  output int           pending,
  output int           result_count
);
  import ant_pkg::*;

  logic [63:0] tbl_ahi [TABLE_ENTRIES];
  logic [63:0] tbl_alo [TABLE_ENTRIES];
  logic [31:0] tbl_hash [TABLE_ENTRIES];
  logic [31:0] tbl_data [TABLE_ENTRIES];
  logic [15:0] tbl_ver [TABLE_ENTRIES];
  logic [7:0]  tbl_kind [TABLE_ENTRIES];
  logic [31:0] tbl_created [TABLE_ENTRIES];
  logic [31:0] tbl_last [TABLE_ENTRIES];
  int          next_free;
  logic [31:0] timeout;
  logic [319:0] expected_q [$];

  function automatic bit is_vacant(int i);
    return tbl_ahi[i] == 64'd0 && tbl_alo[i] == 64'd0;
  endfunction

  function automatic int lowest_vacant();
    for (int i = 0; i < TABLE_ENTRIES; i++) if (is_vacant(i)) return i;
    return TABLE_ENTRIES;
  endfunction

  function automatic logic [319:0] entry_result(int i);
    logic [319:0] r;
    r = '0;
    r[1:0]     = ST_OK;
    r[5:2]     = i[3:0];
    r[69:6]    = tbl_ahi[i];
    r[133:70]  = tbl_alo[i];
    r[165:134] = tbl_hash[i];
    r[197:166] = tbl_data[i];
    r[213:198] = tbl_ver[i];
    r[221:214] = tbl_kind[i];
    r[253:222] = tbl_created[i];
    r[285:254] = tbl_last[i];
    return r;
  endfunction

  function automatic logic [319:0] apply_request(logic [255:0] d);
    logic [2:0]   op;
    logic [31:0]  now_t, elapsed, least;
    logic [63:0]  ahi, alo;
    logic [31:0]  hsh, dat;
    logic [15:0]  ver;
    logic [7:0]   knd;
    int           sl;
    logic [319:0] r;
    op = d[2:0]; now_t = d[34:3]; ahi = d[98:35]; alo = d[162:99];
    hsh = d[194:163]; dat = d[226:195]; ver = d[242:227]; knd = d[250:243];
    sl = d[254:251];
    r = '0;
    r[1:0] = ST_NOTFOUND;
    case (op)
      OP_ADD: begin
        if (next_free >= TABLE_ENTRIES) begin
          r[1:0] = ST_FULL;
        end else begin
          sl = next_free;
          tbl_ahi[sl] = ahi; tbl_alo[sl] = alo; tbl_hash[sl] = hsh;
          tbl_data[sl] = dat; tbl_created[sl] = now_t; tbl_last[sl] = now_t;
          tbl_ver[sl] = ver; tbl_kind[sl] = knd;
          next_free = lowest_vacant();
          r = entry_result(sl);
        end
      end
      OP_FIND_A: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (tbl_ahi[i] == ahi && tbl_alo[i] == alo) begin
            r = entry_result(i);
            break;
          end
      end
      OP_FIND_H: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (tbl_hash[i] == hsh) begin
            r = entry_result(i);
            break;
          end
      end
      OP_UPDATE: begin
        if (sl < TABLE_ENTRIES) begin
          tbl_ver[sl] = ver; tbl_data[sl] = dat; tbl_last[sl] = now_t;
          r = entry_result(sl);
        end
      end
      OP_REMOVE: begin
        if (sl < TABLE_ENTRIES) begin
          tbl_ahi[sl] = '0; tbl_alo[sl] = '0; tbl_hash[sl] = '0;
          next_free = sl;
          r[1:0] = ST_OK;
          r[5:2] = sl[3:0];
        end
      end
      OP_REFRESH: begin
        least = AllOnes;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!is_vacant(i)) begin
            elapsed = now_t - tbl_last[i];
            if (elapsed >= timeout) begin
              tbl_ahi[i] = '0; tbl_alo[i] = '0; tbl_hash[i] = '0;
              next_free = i;
            end else if (timeout - elapsed < least) begin
              least = timeout - elapsed;
            end
          end
        end
        r[1:0] = ST_OK;
        r[317:286] = least;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    logic [319:0] exp_r;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_ahi[i] = '0; tbl_alo[i] = '0; tbl_hash[i] = '0; tbl_data[i] = '0;
        tbl_ver[i] = '0; tbl_kind[i] = '0; tbl_created[i] = '0; tbl_last[i] = '0;
      end
      next_free = 0;
      timeout = '0;
      expected_q.delete();
      err_count = 0;
      result_count = 0;
    end else begin
      if (cfg_we) timeout = cfg_wdata;
      if (in_tvalid && in_tready) expected_q.push_back(apply_request(in_tdata));
      if (out_tvalid && out_tready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result item %h", $time, out_tdata);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r[1:0] != out_tdata[1:0] || exp_r[5:2] != out_tdata[5:2] ||
              exp_r[69:6] != out_tdata[69:6] || exp_r[133:70] != out_tdata[133:70] ||
              exp_r[165:134] != out_tdata[165:134] ||
              exp_r[197:166] != out_tdata[197:166] ||
              exp_r[213:198] != out_tdata[213:198] ||
              exp_r[221:214] != out_tdata[221:214] ||
              exp_r[253:222] != out_tdata[253:222] ||
              exp_r[285:254] != out_tdata[285:254] ||
              exp_r[317:286] != out_tdata[317:286]) begin
            err_count++;
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_tdata);
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* sim/tb_aging_node_table.sv */
// Testbench top for the aging node table: resets the block, writes the
// timeout, drives directed then random items and gives the verdict.
// Depends on ant_pkg, aging_node_table and node_table_checker.
`timescale 1ns / 1ps
module tb_aging_node_table;
  import ant_pkg::*;

  localparam int CycleLimit = 1000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [319:0] out_tdata;
  int           err_count, pending, result_count;
  int           cycles = 0;
  bit           calm = 1'b0;
  bit           hold_off = 1'b0;
  logic [63:0]  used_ahi [$];
  logic [31:0]  used_hash [$];
  logic [31:0]  tick = 32'd100;

  always #10 clk = ~clk;

  aging_node_table #(.TABLE_ENTRIES(16)) i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  node_table_checker #(.TABLE_ENTRIES(16)) i_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .err_count(err_count), .pending(pending), .result_count(result_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, none while calm; ready held low during a hold-off.
  initial begin
    int gap;
    while (1) begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        out_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Valid stays high after an item is taken; the next item replaces its data,
  // and only an idle burst or the end of a phase lowers it.
  task automatic send(logic [2:0] op, logic [31:0] now_t, logic [63:0] ahi,
                      logic [63:0] alo, logic [31:0] hsh, logic [31:0] dat,
                      logic [15:0] ver, logic [7:0] knd, logic [3:0] sl);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, sl, knd, ver, dat, hsh, alo, ahi, now_t, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_timeout(logic [31:0] value);
    stop_input();
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random item, mostly adds and lookups of addresses and hashes seen before.
  task automatic random_item();
    logic [2:0]  op;
    logic [63:0] ahi, alo;
    logic [31:0] hsh;
    int          pick;
    tick = tick + $urandom_range(0, 40);
    pick = $urandom_range(0, 99);
    op = pick < 30 ? OP_ADD : pick < 45 ? OP_FIND_A : pick < 58 ? OP_FIND_H :
         pick < 72 ? OP_UPDATE : pick < 84 ? OP_REMOVE : pick < 97 ? OP_REFRESH :
         3'($urandom_range(6, 7));
    ahi = {$urandom, $urandom};
    alo = {$urandom, $urandom};
    hsh = $urandom;
    if (used_ahi.size() > 0 && $urandom_range(0, 2) != 0) begin
      pick = $urandom_range(0, used_ahi.size() - 1);
      ahi = used_ahi[pick];
      alo = {ahi[31:0], ahi[63:32]};
      hsh = used_hash[pick];
    end
    if ($urandom_range(0, 40) == 0) begin
      ahi = '0; alo = '0;
    end
    if (op == OP_ADD) begin
      used_ahi.push_back(ahi);
      used_hash.push_back(hsh);
      if (used_ahi.size() > 24) begin
        void'(used_ahi.pop_front());
        void'(used_hash.pop_front());
      end
      alo = {ahi[31:0], ahi[63:32]};
    end
    send(op, tick, ahi, alo, hsh, $urandom, 16'($urandom), 8'($urandom),
         4'($urandom));
  endtask

  initial begin
    logic [31:0] timeouts [5];
    timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd300, 32'd1, 32'd2000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, every operation, full table, expiry.
    set_timeout(32'hFFFF_FFFF);
    send(OP_ADD, '1, '1, '1, '1, '1, '1, '1, 4'd0);
    send(OP_ADD, '0, '0, '0, '0, '0, '0, '0, 4'd0);
    send(OP_FIND_A, 32'd5, '1, '1, '0, '0, '0, '0, 4'd0);
    send(OP_FIND_A, 32'd5, 64'd7, 64'd9, '0, '0, '0, '0, 4'd0);
    send(OP_FIND_H, 32'd5, '0, '0, '0, '0, '0, '0, 4'd0);
    send(OP_FIND_H, 32'd5, '0, '0, 32'h1234, '0, '0, '0, 4'd0);
    send(OP_UPDATE, 32'd9, '0, '0, '0, 32'hA5A5_5A5A, 16'h8001, '0, 4'd15);
    send(OP_REMOVE, 32'd9, '0, '0, '0, '0, '0, '0, 4'd0);
    send(OP_FIND_A, 32'd9, '0, '0, '0, '0, '0, '0, 4'd0);
    for (int i = 1; i <= 17; i++)
      send(OP_ADD, 32'd10 + i, 64'(i), 64'(i) << 60, 32'(i), 32'(i), 16'(i),
           8'(i), 4'd0);
    send(OP_REFRESH, 32'd50, '0, '0, '0, '0, '0, '0, 4'd0);
    send(3'd6, 32'd50, '1, '1, '1, '1, '1, '1, 4'd15);
    send(3'd7, 32'd50, '0, '0, '0, '0, '0, '0, 4'd0);
    set_timeout(32'd0);
    send(OP_REFRESH, 32'd60, '0, '0, '0, '0, '0, '0, 4'd0);
    send(OP_REFRESH, 32'd60, '0, '0, '0, '0, '0, '0, 4'd0);

    // Long receiver hold-off while items keep coming.
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 4; i++) random_item();
    join

    for (int p = 0; p < 5; p++) begin
      set_timeout(timeouts[p]);
      if (p == 4) calm = 1'b1;
      for (int n = 0; n < 150; n++) random_item();
    end

    stop_input();
    repeat (100) @(posedge clk);
    $display("Ran %0d result items over directed cases and five timeout settings.",
             result_count);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
